@@ rtl/taq_pkg.sv @@
// Package for the tracked action queue: sizes, kind codes, state type, history record.
package taq_pkg;
  localparam int QueueDepth   = 32;
  localparam int HistoryDepth = 64;
  localparam int QW = $clog2(QueueDepth);
  localparam int HW = $clog2(HistoryDepth);

  localparam logic [2:0] KIND_ENQ    = 3'd0;
  localparam logic [2:0] KIND_DEQ    = 3'd1;
  localparam logic [2:0] KIND_RUN    = 3'd2;
  localparam logic [2:0] KIND_DONE   = 3'd3;
  localparam logic [2:0] KIND_LOOKUP = 3'd4;
  localparam logic [2:0] KIND_LATEST = 3'd5;

  localparam logic [1:0] CFG_CMD_ACTION = 2'd0;
  localparam logic [1:0] CFG_NO_CMD     = 2'd1;
  localparam logic [1:0] CFG_UNSUP      = 2'd2;

  localparam logic [2:0] ST_ACCEPTED = 3'd0;
  localparam logic [2:0] ST_RUNNING  = 3'd1;
  localparam logic [2:0] ST_FAILED   = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_CHECK, S_WRITE, S_REPORT, S_DEQ
  } state_t;

  typedef struct packed {
    logic [7:0] code;
    logic       cok;
    logic [7:0] ctype;
    logic [2:0] status;
    logic [2:0] atype;
  } hist_rec_t;

  typedef struct packed {
    logic [31:0] ident;
    hist_rec_t   rec;
    logic [31:0] t_acc;
    logic [31:0] t_run;
    logic [31:0] t_done;
  } hist_entry_t;
endpackage

@@ rtl/taq_hist_ram.sv @@
// History memory: one write port and one registered read port.
module taq_hist_ram (
  input  logic                    clk,
  input  logic                    we,
  input  logic [taq_pkg::HW-1:0]  waddr,
  input  taq_pkg::hist_entry_t    wdata,
  input  logic [taq_pkg::HW-1:0]  raddr,
  output taq_pkg::hist_entry_t    rdata
);
  taq_pkg::hist_entry_t mem [taq_pkg::HistoryDepth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/tracked_action_queue_top.sv @@
// Top level of the tracked action queue: FIFO memory, history scan and result register.
// Each command word (start while not busy) yields one result word on strobe, held
// for exactly one cycle; the receiver cannot stall it. Enqueue and dequeue go through
// S_DEQ then S_REPORT, latest through S_CHECK then S_REPORT, an unknown kind straight
// to S_REPORT. Mark and lookup walk the history memory one entry a cycle through its
// single read port; a hit goes on to S_WRITE then S_REPORT, a miss to S_REPORT.
// Busy is high from acceptance until the strobe cycle. No clearing pass is needed.
module tracked_action_queue_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic [2:0]  kind,
  input  logic [2:0]  action_type,
  input  logic [7:0]  cmd_type,
  input  logic [31:0] payload,
  input  logic [31:0] time_ms,
  input  logic [31:0] target_id,
  input  logic [2:0]  done_status,
  input  logic        done_ok,
  input  logic [7:0]  done_code,
  output logic        strobe,
  output logic        ok,
  output logic [31:0] result_id,
  output logic [2:0]  result_type,
  output logic [31:0] result_payload,
  output logic [2:0]  result_status,
  output logic        result_ok_flag,
  output logic [7:0]  result_code,
  output logic [31:0] accepted_ms,
  output logic [31:0] started_ms,
  output logic [31:0] completed_ms,
  output logic [4:0]  depth,
  output logic [15:0] drops
);
  localparam int QW = taq_pkg::QW;
  localparam int HW = taq_pkg::HW;
  localparam int CW = HW + 1;

  // configuration
  logic [2:0] cmd_action;
  logic [7:0] no_cmd, unsup;
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_action <= 3'd1;
      no_cmd     <= 8'd0;
      unsup      <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        taq_pkg::CFG_CMD_ACTION: cmd_action <= cfg_data[2:0];
        taq_pkg::CFG_NO_CMD:     no_cmd     <= cfg_data;
        taq_pkg::CFG_UNSUP:      unsup      <= cfg_data;
        default: ;
      endcase
    end
  end

  // latched command word
  logic [2:0]  k_kind, k_atype, k_fst;
  logic [7:0]  k_ctype, k_ccode;
  logic [31:0] k_pay, k_time, k_id;
  logic        k_cok;

  // control state
  taq_pkg::state_t state, state_next;
  logic [QW-1:0] read_ptr, write_ptr;
  logic [15:0]   drop_counter;
  logic [31:0]   next_ident;
  logic [HW-1:0] hist_oldest;
  logic [CW-1:0] hist_count;
  logic [CW-1:0] scan_i;         // entries issued
  logic [HW-1:0] hit_slot;

  // FIFO memory: type, payload, id in one word
  logic [66:0] fifo_mem [taq_pkg::QueueDepth];
  logic [66:0] fifo_q;
  logic        fifo_we;
  logic [31:0] nid;
  always_ff @(posedge clk) begin
    if (fifo_we) fifo_mem[write_ptr] <= {k_atype, k_pay, nid};
    fifo_q <= fifo_mem[read_ptr];
  end

  // history memory
  logic          h_we;
  logic [HW-1:0] h_waddr, h_raddr;
  taq_pkg::hist_entry_t h_wdata, h_q;
  taq_pkg::hist_entry_t cur;
  taq_hist_ram u_hist (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_q)
  );

  function automatic logic [HW-1:0] hslot(input logic [HW-1:0] b, input logic [CW-1:0] o);
    logic [CW:0] s;
    s = {2'b0, b} + {1'b0, o};
    if (s >= (CW+1)'(taq_pkg::HistoryDepth)) s = s - (CW+1)'(taq_pkg::HistoryDepth);
    return s[HW-1:0];
  endfunction

  logic [QW-1:0] nw;
  logic          fifo_full, fifo_empty;
  logic [HW-1:0] new_slot;
  assign nw         = write_ptr + QW'(1);
  assign fifo_full  = (nw == read_ptr);
  assign fifo_empty = (read_ptr == write_ptr);
  assign nid        = (next_ident == 32'd0) ? 32'd1 : next_ident;
  assign new_slot   = (hist_count < CW'(taq_pkg::HistoryDepth)) ?
                      hslot(hist_oldest, hist_count) : hist_oldest;

  logic scan_valid;   // a read issued last cycle belongs to the scan
  logic found;
  logic [CW-1:0] latest_off;
  assign latest_off = hist_count - CW'(1);

  always_comb begin
    state_next = state;
    h_raddr = hslot(hist_oldest, scan_i);
    // at acceptance read the newest entry for latest, else the oldest to start a scan
    if (state == taq_pkg::S_IDLE)
      h_raddr = (start && kind == taq_pkg::KIND_LATEST) ?
                hslot(hist_oldest, latest_off) : hist_oldest;
    case (state)
      taq_pkg::S_IDLE:  if (start) begin
        case (kind)
          taq_pkg::KIND_ENQ, taq_pkg::KIND_DEQ: state_next = taq_pkg::S_DEQ;
          taq_pkg::KIND_RUN, taq_pkg::KIND_DONE, taq_pkg::KIND_LOOKUP:
            state_next = taq_pkg::S_SCAN;
          taq_pkg::KIND_LATEST: state_next = taq_pkg::S_CHECK;
          default: state_next = taq_pkg::S_REPORT;
        endcase
      end
      taq_pkg::S_SCAN: begin
        if (scan_valid && h_q.ident == k_id) state_next = taq_pkg::S_WRITE;
        else if (scan_i >= hist_count) state_next = taq_pkg::S_REPORT;
      end
      taq_pkg::S_CHECK:  state_next = taq_pkg::S_REPORT;
      taq_pkg::S_DEQ:    state_next = taq_pkg::S_REPORT;
      taq_pkg::S_WRITE:  state_next = taq_pkg::S_REPORT;
      taq_pkg::S_REPORT: state_next = taq_pkg::S_IDLE;
      default:           state_next = taq_pkg::S_IDLE;
    endcase
  end

  assign busy = (state != taq_pkg::S_IDLE);
  assign fifo_we = (state == taq_pkg::S_DEQ) && (k_kind == taq_pkg::KIND_ENQ) && !fifo_full;

  // history write: enqueue entry or modified hit
  always_comb begin
    h_we = 1'b0;
    h_waddr = new_slot;
    h_wdata = cur;
    if (fifo_we) begin
      h_we = 1'b1;
      h_wdata.ident = nid;
      h_wdata.rec.atype  = k_atype;
      h_wdata.rec.status = taq_pkg::ST_ACCEPTED;
      h_wdata.rec.ctype  = (k_atype == cmd_action) ? k_ctype : no_cmd;
      h_wdata.rec.cok    = 1'b0;
      h_wdata.rec.code   = unsup;
      h_wdata.t_acc  = k_time;
      h_wdata.t_run  = 32'd0;
      h_wdata.t_done = 32'd0;
    end else if (state == taq_pkg::S_WRITE && k_kind != taq_pkg::KIND_LOOKUP) begin
      h_we = 1'b1;
      h_waddr = hit_slot;
      if (k_kind == taq_pkg::KIND_RUN) begin
        h_wdata.rec.status = taq_pkg::ST_RUNNING;
        h_wdata.t_run = k_time;
      end else begin
        h_wdata.rec.status = (k_fst > taq_pkg::ST_FAILED) ? taq_pkg::ST_FAILED : k_fst;
        h_wdata.rec.cok  = k_cok;
        h_wdata.rec.code = k_ccode;
        h_wdata.t_done = k_time;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= taq_pkg::S_IDLE;
      read_ptr <= '0;
      write_ptr <= '0;
      drop_counter <= '0;
      next_ident <= 32'd1;
      hist_oldest <= '0;
      hist_count <= '0;
      scan_i <= '0;
      scan_valid <= 1'b0;
      found <= 1'b0;
      strobe <= 1'b0;
    end else begin
      state <= state_next;
      strobe <= (state == taq_pkg::S_REPORT);
      if (state == taq_pkg::S_IDLE && start) begin
        scan_i <= (kind == taq_pkg::KIND_LOOKUP && target_id == 32'd0) ? hist_count : CW'(1);
        scan_valid <= !(kind == taq_pkg::KIND_LOOKUP && target_id == 32'd0)
                      && hist_count != '0;
        found <= 1'b0;
      end
      if (state == taq_pkg::S_SCAN) begin
        if (scan_valid && h_q.ident == k_id) begin
          found <= 1'b1;
          cur <= h_q;
          hit_slot <= hslot(hist_oldest, scan_i - CW'(1));
        end
        scan_valid <= (scan_i < hist_count);
        if (scan_i < hist_count) scan_i <= scan_i + CW'(1);
      end
      if (state == taq_pkg::S_CHECK) begin
        found <= (hist_count != '0);
        cur <= h_q;
      end
      if (state == taq_pkg::S_DEQ) begin
        if (k_kind == taq_pkg::KIND_ENQ) begin
          if (fifo_full) drop_counter <= drop_counter + 16'd1;
          else begin
            write_ptr <= nw;
            next_ident <= nid + 32'd1;
            if (hist_count < CW'(taq_pkg::HistoryDepth)) hist_count <= hist_count + CW'(1);
            else hist_oldest <= hslot(hist_oldest, CW'(1));
          end
        end else if (!fifo_empty) read_ptr <= read_ptr + QW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == taq_pkg::S_IDLE && start) begin
      k_kind <= kind; k_atype <= action_type; k_ctype <= cmd_type; k_pay <= payload;
      k_time <= time_ms; k_id <= target_id; k_fst <= done_status;
      k_cok <= done_ok; k_ccode <= done_code;
    end
  end

  // result word; register pointers updated in S_DEQ so depth is final here
  logic         dq_ok, eq_ok;
  logic [66:0]  dq_word;
  logic [31:0]  eq_id;
  always_ff @(posedge clk) begin
    if (state == taq_pkg::S_DEQ) begin
      dq_ok <= !fifo_empty; dq_word <= fifo_q;
      eq_ok <= !fifo_full;  eq_id <= nid;
    end
  end

  always_ff @(posedge clk) begin
    if (state == taq_pkg::S_REPORT) begin
      ok <= 1'b0; result_id <= '0; result_type <= '0; result_payload <= '0;
      result_status <= '0; result_ok_flag <= 1'b0; result_code <= '0;
      accepted_ms <= '0; started_ms <= '0; completed_ms <= '0;
      depth <= 5'(write_ptr - read_ptr);
      drops <= drop_counter;
      case (k_kind)
        taq_pkg::KIND_ENQ: if (eq_ok) begin ok <= 1'b1; result_id <= eq_id; end
        taq_pkg::KIND_DEQ: if (dq_ok) begin
          ok <= 1'b1; result_id <= dq_word[31:0];
          result_payload <= dq_word[63:32]; result_type <= dq_word[66:64];
        end
        taq_pkg::KIND_RUN, taq_pkg::KIND_DONE: ok <= found;
        taq_pkg::KIND_LOOKUP, taq_pkg::KIND_LATEST: if (found) begin
          ok <= 1'b1; result_id <= cur.ident; result_type <= cur.rec.atype;
          result_payload <= {24'd0, cur.rec.ctype}; result_status <= cur.rec.status;
          result_ok_flag <= cur.rec.cok; result_code <= cur.rec.code;
          accepted_ms <= cur.t_acc; started_ms <= cur.t_run; completed_ms <= cur.t_done;
        end
        default: ;
      endcase
    end
  end
endmodule

@@ rtl/taq_checker.sv @@
// Port-level checker for the tracked action queue, bound to the top level.
module taq_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        strobe,
  input logic        ok,
  input logic [31:0] result_id,
  input logic [4:0]  depth
);
  a_strobe_idle: assert property (@(posedge clk) disable iff (rst) strobe |-> !busy)
    else $error("strobe while busy");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("no busy after accept");
  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !strobe) else $error("strobe repeated");
  a_result_known: assert property (@(posedge clk) disable iff (rst)
    strobe |-> !$isunknown({ok, result_id, depth}))
    else $error("unknown result word on strobe");
endmodule

bind tracked_action_queue_top taq_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .strobe(strobe),
  .ok(ok), .result_id(result_id), .depth(depth)
);
